@@ rtl/core/jsri_pkg.sv @@
// Shared types, constants and helper functions of the joystick servo rate integrator.
// No dependencies; the design files refer to this package by scoped names, the bench imports it.
`default_nettype none

package jsri_pkg;

   // Servo set
   localparam int SERVO_COUNT = 6;
   localparam int WIDTH_BITS  = 12;
   localparam int PACK_PITCH  = 12;
   localparam int SUM_BITS    = WIDTH_BITS + 2;

   localparam int SERVO_BASE     = 0;
   localparam int SERVO_SHOULDER = 1;
   localparam int SERVO_ELBOW    = 2;
   localparam int SERVO_WRIST    = 3;
   localparam int SERVO_TURN     = 4;
   localparam int SERVO_CLAW     = 5;
   localparam int PRESET_COUNT   = 5;
   localparam int GROUP_SIZE     = 3;

   // Step scaling: q = (mag * gain * ceil(2^36 / divisor)) >> 36, exact for gain*mag < 2^21
   localparam int STEP_BITS   = 7;
   localparam int QUOT_BITS   = 6;
   localparam int MAG_BITS    = 16;
   localparam int COEF_BITS   = 28;
   localparam int PROD_BITS   = MAG_BITS + COEF_BITS;
   localparam int SCALE_SHIFT = 36;

   localparam longint unsigned SCALE_ONE     = 64'd1 << SCALE_SHIFT;
   localparam longint unsigned ARM_DIVISOR   = 64'd32175;
   localparam longint unsigned TURN_DIVISOR  = 64'd32157;
   localparam longint unsigned ARM_GAIN      = 64'd3;
   localparam longint unsigned WRIST_GAIN    = 64'd10;
   localparam longint unsigned TURN_GAIN     = 64'd45;
   localparam longint unsigned RECIP_ARM     = (SCALE_ONE + ARM_DIVISOR - 64'd1) / ARM_DIVISOR;
   localparam longint unsigned RECIP_TURN    = (SCALE_ONE + TURN_DIVISOR - 64'd1) / TURN_DIVISOR;
   localparam logic [COEF_BITS-1:0] COEF_ARM   = COEF_BITS'(ARM_GAIN * RECIP_ARM);
   localparam logic [COEF_BITS-1:0] COEF_WRIST = COEF_BITS'(WRIST_GAIN * RECIP_ARM);
   localparam logic [COEF_BITS-1:0] COEF_TURN  = COEF_BITS'(TURN_GAIN * RECIP_TURN);

   // Configuration
   localparam int DZ_BITS       = 15;
   localparam int BOUND_BITS    = 36;
   localparam int PRESET_BITS   = 60;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 60;

   localparam logic [DZ_BITS-1:0]     DEAD_ZONE_RESET    = 15'd5000;
   localparam logic [BOUND_BITS-1:0]  LOWER_BOUNDS_RESET = {12'd1000, 12'd1000, 12'd1000};
   localparam logic [BOUND_BITS-1:0]  UPPER_BOUNDS_RESET = {12'd2000, 12'd2000, 12'd2000};
   localparam logic [PRESET_BITS-1:0] DRIVE_PRESET_RESET = 60'd422336192005326000;
   localparam logic [PRESET_BITS-1:0] READY_PRESET_RESET = 60'd422315569453057500;

   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET     = 12'd1500;
   localparam logic [WIDTH_BITS-1:0] LAST_SENT_RESET = 12'd1501;

   localparam logic [3:0] CLAW_TOGGLE_BUTTON = 4'd3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DEAD_ZONE      = 3'd0,
      CSR_LOWER_BOUNDS_A = 3'd1,
      CSR_LOWER_BOUNDS_B = 3'd2,
      CSR_UPPER_BOUNDS_A = 3'd3,
      CSR_UPPER_BOUNDS_B = 3'd4,
      CSR_DRIVE_PRESET   = 3'd5,
      CSR_READY_PRESET   = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      CMD_JOYSTICK      = 3'd0,
      CMD_BUTTON        = 3'd1,
      CMD_RESET         = 3'd2,
      CMD_STORAGE_READY = 3'd3,
      CMD_READY_DRIVE   = 3'd4,
      CMD_DRIVE_READY   = 3'd5,
      CMD_RESEND        = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      MSG_ARM           = 3'd0,
      MSG_RESET         = 3'd1,
      MSG_STORAGE_READY = 3'd2,
      MSG_READY_DRIVE   = 3'd3,
      MSG_DRIVE_READY   = 3'd4
   } msg_type;

   typedef logic [WIDTH_BITS-1:0]        width_type;
   typedef width_type [SERVO_COUNT-1:0]  width_set_type;
   typedef logic signed [STEP_BITS-1:0]  step_type;
   typedef step_type [SERVO_COUNT-1:0]   step_set_type;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [15:0] stick1_x;
      logic signed [15:0] stick1_y;
      logic signed [15:0] left_trigger;
      logic signed [15:0] stick2_x;
      logic signed [15:0] stick2_y;
      logic signed [15:0] right_trigger;
      logic [3:0]         button_code;
   } req_payload_type;

   typedef struct packed {
      logic        send;
      logic [2:0]  message;
      logic [11:0] base_width;
      logic [11:0] shoulder_width;
      logic [11:0] elbow_width;
      logic [11:0] wrist_width;
      logic [11:0] wrist_turn_width;
      logic [11:0] claw_width;
   } rsp_payload_type;

   typedef struct packed {
      logic [DZ_BITS-1:0]     dead_zone;
      logic [BOUND_BITS-1:0]  lower_bounds_a;
      logic [BOUND_BITS-1:0]  lower_bounds_b;
      logic [BOUND_BITS-1:0]  upper_bounds_a;
      logic [BOUND_BITS-1:0]  upper_bounds_b;
      logic [PRESET_BITS-1:0] drive_preset;
      logic [PRESET_BITS-1:0] ready_preset;
   } cfg_type;

   // Sign and magnitude of an axis after the dead zone
   typedef struct packed {
      logic                neg;
      logic [MAG_BITS-1:0] mag;
   } mag_type;

   // Inside the zone gives 0, beyond it moves toward 0, on its edge passes unchanged
   function automatic mag_type dead_band(input logic signed [15:0] v,
                                         input logic [DZ_BITS-1:0] dz);
      logic [16:0] v_ext;
      logic [16:0] abs_v;
      logic [16:0] dz_ext;
      logic [16:0] diff;
      mag_type     r;
      v_ext  = {v[15], v};
      abs_v  = v[15] ? (17'd0 - v_ext) : v_ext;
      dz_ext = {2'b00, dz};
      diff   = abs_v - dz_ext;
      r.neg  = v[15];
      if (abs_v < dz_ext) begin
         r.mag = '0;
      end else if (abs_v > dz_ext) begin
         r.mag = diff[MAG_BITS-1:0];
      end else begin
         r.mag = abs_v[MAG_BITS-1:0];
      end
      return r;
   endfunction

   // Signed step, truncated toward zero
   function automatic step_type scaled_step(input logic [MAG_BITS-1:0] mag,
                                            input logic neg,
                                            input logic [COEF_BITS-1:0] coef);
      logic [PROD_BITS-1:0] prod;
      logic [STEP_BITS-1:0] q_ext;
      prod  = PROD_BITS'(mag) * PROD_BITS'(coef);
      q_ext = {1'b0, prod[SCALE_SHIFT +: QUOT_BITS]};
      return step_type'(neg ? (STEP_BITS'(0) - q_ext) : q_ext);
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/jsri_csr_regs.sv @@
// Configuration register file: dead zone, servo bounds and pose presets.
// Depends on jsri_pkg.
`default_nettype none

module jsri_csr_regs (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                write_en,
   input  wire logic [jsri_pkg::CSR_IDX_BITS-1:0]   write_index,
   input  wire logic [jsri_pkg::CSR_DATA_BITS-1:0]  write_data,
   output jsri_pkg::cfg_type                        cfg
);

   jsri_pkg::cfg_type cfg_ff;
   jsri_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (write_index)
            jsri_pkg::CSR_DEAD_ZONE:
               cfg_in.dead_zone = write_data[jsri_pkg::DZ_BITS-1:0];
            jsri_pkg::CSR_LOWER_BOUNDS_A:
               cfg_in.lower_bounds_a = write_data[jsri_pkg::BOUND_BITS-1:0];
            jsri_pkg::CSR_LOWER_BOUNDS_B:
               cfg_in.lower_bounds_b = write_data[jsri_pkg::BOUND_BITS-1:0];
            jsri_pkg::CSR_UPPER_BOUNDS_A:
               cfg_in.upper_bounds_a = write_data[jsri_pkg::BOUND_BITS-1:0];
            jsri_pkg::CSR_UPPER_BOUNDS_B:
               cfg_in.upper_bounds_b = write_data[jsri_pkg::BOUND_BITS-1:0];
            jsri_pkg::CSR_DRIVE_PRESET:
               cfg_in.drive_preset = write_data[jsri_pkg::PRESET_BITS-1:0];
            jsri_pkg::CSR_READY_PRESET:
               cfg_in.ready_preset = write_data[jsri_pkg::PRESET_BITS-1:0];
            default: begin
               // unmapped index: dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_zone      <= jsri_pkg::DEAD_ZONE_RESET;
         cfg_ff.lower_bounds_a <= jsri_pkg::LOWER_BOUNDS_RESET;
         cfg_ff.lower_bounds_b <= jsri_pkg::LOWER_BOUNDS_RESET;
         cfg_ff.upper_bounds_a <= jsri_pkg::UPPER_BOUNDS_RESET;
         cfg_ff.upper_bounds_b <= jsri_pkg::UPPER_BOUNDS_RESET;
         cfg_ff.drive_preset   <= jsri_pkg::DRIVE_PRESET_RESET;
         cfg_ff.ready_preset   <= jsri_pkg::READY_PRESET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/core/jsri_step_calc.sv @@
// Dead zone and constant scaling of the stick axes and trigger difference into joint steps.
// Depends on jsri_pkg; purely combinational.
`default_nettype none

module jsri_step_calc (
   input  wire jsri_pkg::req_payload_type     item,
   input  wire logic [jsri_pkg::DZ_BITS-1:0]  dead_zone,
   output jsri_pkg::step_set_type             steps
);

   jsri_pkg::mag_type  x1;
   jsri_pkg::mag_type  y1;
   jsri_pkg::mag_type  x2;
   jsri_pkg::mag_type  y2;
   logic signed [16:0] trig_diff;
   logic [16:0]        trig_abs;

   always_comb begin
      x1 = jsri_pkg::dead_band(item.stick1_x, dead_zone);
      y1 = jsri_pkg::dead_band(item.stick1_y, dead_zone);
      x2 = jsri_pkg::dead_band(item.stick2_x, dead_zone);
      y2 = jsri_pkg::dead_band(item.stick2_y, dead_zone);

      // triggers skip the dead zone; wrist follows right minus left
      trig_diff = {item.right_trigger[15], item.right_trigger}
                - {item.left_trigger[15], item.left_trigger};
      trig_abs  = trig_diff[16] ? (17'd0 - trig_diff) : trig_diff;

      steps[jsri_pkg::SERVO_BASE]     = jsri_pkg::scaled_step(x2.mag, !x2.neg,
                                                              jsri_pkg::COEF_ARM);
      steps[jsri_pkg::SERVO_SHOULDER] = jsri_pkg::scaled_step(y2.mag, !y2.neg,
                                                              jsri_pkg::COEF_ARM);
      steps[jsri_pkg::SERVO_ELBOW]    = jsri_pkg::scaled_step(y1.mag, y1.neg,
                                                              jsri_pkg::COEF_ARM);
      steps[jsri_pkg::SERVO_WRIST]    = jsri_pkg::scaled_step(
                                           trig_abs[jsri_pkg::MAG_BITS-1:0], trig_diff[16],
                                           jsri_pkg::COEF_WRIST);
      steps[jsri_pkg::SERVO_TURN]     = jsri_pkg::scaled_step(x1.mag, x1.neg,
                                                              jsri_pkg::COEF_TURN);
      steps[jsri_pkg::SERVO_CLAW]     = steps[jsri_pkg::SERVO_TURN];
   end

endmodule

`default_nettype wire

@@ rtl/core/jsri_servo_state.sv @@
// Servo width and last-sent state, bounded step update, pose loads and message choice.
// Depends on jsri_pkg; fed by jsri_step_calc and jsri_csr_regs.
`default_nettype none

module jsri_servo_state (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire jsri_pkg::req_payload_type  item,
   input  wire jsri_pkg::step_set_type     steps,
   input  wire jsri_pkg::cfg_type          cfg,
   output jsri_pkg::rsp_payload_type       result
);

   jsri_pkg::width_set_type widths_ff;
   jsri_pkg::width_set_type widths_in;
   jsri_pkg::width_set_type last_ff;
   jsri_pkg::width_set_type last_in;
   jsri_pkg::width_set_type lower;
   jsri_pkg::width_set_type upper;
   jsri_pkg::width_set_type joy_widths;
   jsri_pkg::width_set_type shown;
   logic signed [jsri_pkg::SUM_BITS-1:0] sum_s [jsri_pkg::SERVO_COUNT];
   logic                                  send;
   jsri_pkg::msg_type                     msg;

   // bound unpacking and per-servo step check
   always_comb begin
      for (int i = 0; i < jsri_pkg::GROUP_SIZE; i++) begin
         lower[i] = jsri_pkg::WIDTH_BITS'(cfg.lower_bounds_a[i*jsri_pkg::PACK_PITCH +:
                                                            jsri_pkg::PACK_PITCH]);
         upper[i] = jsri_pkg::WIDTH_BITS'(cfg.upper_bounds_a[i*jsri_pkg::PACK_PITCH +:
                                                            jsri_pkg::PACK_PITCH]);
         lower[i+jsri_pkg::GROUP_SIZE] = jsri_pkg::WIDTH_BITS'(
            cfg.lower_bounds_b[i*jsri_pkg::PACK_PITCH +: jsri_pkg::PACK_PITCH]);
         upper[i+jsri_pkg::GROUP_SIZE] = jsri_pkg::WIDTH_BITS'(
            cfg.upper_bounds_b[i*jsri_pkg::PACK_PITCH +: jsri_pkg::PACK_PITCH]);
      end
      for (int i = 0; i < jsri_pkg::SERVO_COUNT; i++) begin
         sum_s[i] = $signed({2'b00, widths_ff[i]})
                  + $signed({{(jsri_pkg::SUM_BITS-jsri_pkg::STEP_BITS)
                              {steps[i][jsri_pkg::STEP_BITS-1]}}, steps[i]});
         if (steps[i] != '0
             && sum_s[i] <= $signed({2'b00, upper[i]})
             && sum_s[i] >= $signed({2'b00, lower[i]})) begin
            joy_widths[i] = sum_s[i][jsri_pkg::WIDTH_BITS-1:0];
         end else begin
            joy_widths[i] = widths_ff[i];
         end
      end
   end

   // command decode
   always_comb begin
      widths_in = widths_ff;
      last_in   = last_ff;
      send      = 1'b0;
      msg       = jsri_pkg::MSG_ARM;
      case (item.command)
         jsri_pkg::CMD_JOYSTICK: begin
            widths_in = joy_widths;
            if (joy_widths != last_ff) begin
               send    = 1'b1;
               last_in = joy_widths;
            end
         end
         jsri_pkg::CMD_BUTTON: begin
            if (item.button_code == jsri_pkg::CLAW_TOGGLE_BUTTON) begin
               widths_in[jsri_pkg::SERVO_CLAW] =
                  (widths_ff[jsri_pkg::SERVO_CLAW] == lower[jsri_pkg::SERVO_CLAW]) ?
                  upper[jsri_pkg::SERVO_CLAW] : lower[jsri_pkg::SERVO_CLAW];
            end
         end
         jsri_pkg::CMD_RESET, jsri_pkg::CMD_STORAGE_READY, jsri_pkg::CMD_DRIVE_READY: begin
            for (int i = 0; i < jsri_pkg::PRESET_COUNT; i++) begin
               widths_in[i] = jsri_pkg::WIDTH_BITS'(
                  cfg.ready_preset[i*jsri_pkg::PACK_PITCH +: jsri_pkg::PACK_PITCH]);
            end
            widths_in[jsri_pkg::SERVO_CLAW] = lower[jsri_pkg::SERVO_CLAW];
            last_in = widths_in;
            send    = 1'b1;
            if (item.command == jsri_pkg::CMD_RESET) begin
               msg = jsri_pkg::MSG_RESET;
            end else if (item.command == jsri_pkg::CMD_STORAGE_READY) begin
               msg = jsri_pkg::MSG_STORAGE_READY;
            end else begin
               msg = jsri_pkg::MSG_DRIVE_READY;
            end
         end
         jsri_pkg::CMD_READY_DRIVE: begin
            for (int i = 0; i < jsri_pkg::PRESET_COUNT; i++) begin
               widths_in[i] = jsri_pkg::WIDTH_BITS'(
                  cfg.drive_preset[i*jsri_pkg::PACK_PITCH +: jsri_pkg::PACK_PITCH]);
            end
            widths_in[jsri_pkg::SERVO_CLAW] = upper[jsri_pkg::SERVO_CLAW];
            last_in = widths_in;
            send    = 1'b1;
            msg     = jsri_pkg::MSG_READY_DRIVE;
         end
         jsri_pkg::CMD_RESEND: begin
            send = 1'b1;
         end
         default: begin
            // unused command code: no change, nothing sent
         end
      endcase
   end

   // result word
   always_comb begin
      shown = (item.command == jsri_pkg::CMD_RESEND) ? last_ff : widths_in;
      result.send             = send;
      result.message          = msg;
      result.base_width       = shown[jsri_pkg::SERVO_BASE];
      result.shoulder_width   = shown[jsri_pkg::SERVO_SHOULDER];
      result.elbow_width      = shown[jsri_pkg::SERVO_ELBOW];
      result.wrist_width      = shown[jsri_pkg::SERVO_WRIST];
      result.wrist_turn_width = shown[jsri_pkg::SERVO_TURN];
      result.claw_width       = shown[jsri_pkg::SERVO_CLAW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         widths_ff <= {jsri_pkg::SERVO_COUNT{jsri_pkg::WIDTH_RESET}};
         last_ff   <= {jsri_pkg::SERVO_COUNT{jsri_pkg::LAST_SENT_RESET}};
      end else if (advance) begin
         widths_ff <= widths_in;
         last_ff   <= last_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/joystick_servo_rate_integrator_unit.sv @@
// Joystick servo rate integrator, top level.
// Request to result: the input register, then the result register.
// Throughput: one item per cycle unless results stall; state updates with each result.
// Reset (synchronous, active high): widths 1500, last-sent set 1501, registers to defaults,
// both channels empty. Depends on jsri_pkg, jsri_csr_regs, jsri_step_calc, jsri_servo_state.
`default_nettype none

module joystick_servo_rate_integrator_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire jsri_pkg::req_payload_type           req_payload,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output jsri_pkg::rsp_payload_type                rsp_payload,
   // register write port
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [jsri_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [jsri_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   // Pipeline:
   //   stage 1: in_item_ff holds the accepted request.
   //   stage 2: rsp_payload_ff holds the result; the servo state is updated on the
   //            same edge that loads it, so the next item sees the new widths.
   // The result register frees itself on a transfer, so stage 1 may advance in the
   // same cycle the consumer takes the previous result.

   logic                       in_valid_ff;
   logic                       in_valid_in;
   jsri_pkg::req_payload_type  in_item_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   jsri_pkg::rsp_payload_type  rsp_payload_ff;

   logic                       out_free;
   logic                       advance;
   logic                       accept;

   jsri_pkg::cfg_type          cfg;
   jsri_pkg::step_set_type     steps;
   jsri_pkg::rsp_payload_type  result;

   // Handshake control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         rsp_payload_ff <= result;
      end
   end

   // Registers accept a write in every cycle
   assign csr_ready = 1'b1;

   jsri_csr_regs u_csr_regs (
      .clock       (clock),
      .reset       (reset),
      .write_en    (csr_valid),
      .write_index (csr_index),
      .write_data  (csr_data),
      .cfg         (cfg)
   );

   // Dead zone and scaling of the held item
   jsri_step_calc u_step_calc (
      .item      (in_item_ff),
      .dead_zone (cfg.dead_zone),
      .steps     (steps)
   );

   // Bounded update, pose loads, change detection
   jsri_servo_state u_servo_state (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .steps   (steps),
      .cfg     (cfg),
      .result  (result)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // Pose commands always send a message with the new set
   assert property (@(posedge clock) disable iff (reset)
      (advance && (in_item_ff.command == jsri_pkg::CMD_RESET
                   || in_item_ff.command == jsri_pkg::CMD_STORAGE_READY
                   || in_item_ff.command == jsri_pkg::CMD_READY_DRIVE
                   || in_item_ff.command == jsri_pkg::CMD_DRIVE_READY))
      |=> (rsp_valid_ff && rsp_payload_ff.send))
      else $error("pose command result not sent");

   // Ready-to-drive carries its own message code
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.command == jsri_pkg::CMD_READY_DRIVE)
      |=> (rsp_payload_ff.message == jsri_pkg::MSG_READY_DRIVE))
      else $error("ready-to-drive message code wrong");

   // Button presses never send
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_item_ff.command == jsri_pkg::CMD_BUTTON)
      |=> (!rsp_payload_ff.send && rsp_payload_ff.message == jsri_pkg::MSG_ARM))
      else $error("button result marked as sent");

endmodule

`default_nettype wire

@@ bench/joystick_servo_rate_integrator_unit_tb.sv @@
// Self-checking bench for joystick_servo_rate_integrator_unit: a cycle-free model of the arm
// state predicts each result, which is checked field by field. Needs jsri_pkg and the DUT only.
`timescale 1ns / 1ps

module joystick_servo_rate_integrator_unit_tb;
   import jsri_pkg::*;

   // Step scaling, integer and truncating toward zero
   localparam int ARM_RATE   = 3;
   localparam int ARM_SPAN   = 32175;
   localparam int WRIST_RATE = 10;
   localparam int TURN_RATE  = 45;
   localparam int TURN_SPAN  = 32157;

   localparam logic [2:0] CMD_UNUSED       = 3'd7;   // not decoded, must be ignored
   localparam logic [2:0] CSR_UNUSED_INDEX = 3'd7;   // past the register file
   localparam int         CYCLE_LIMIT      = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid   = 1'b0;
   logic            csr_ready;
   logic [2:0]      csr_index   = '0;
   logic [59:0]     csr_data    = '0;

   // Idle/stall rates in percent, set per traffic phase
   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;

   int cycle_count     = 0;
   int mismatch_count  = 0;
   int requests_sent   = 0;
   int results_checked = 0;
   int sends_seen      = 0;
   int csr_writes      = 0;

   // Predicted arm state and register shadow (power-up values)
   logic [14:0] cfg_dead_zone = 15'd5000;
   logic [35:0] cfg_lower_a   = 36'd16781313000;
   logic [35:0] cfg_lower_b   = 36'd16781313000;
   logic [35:0] cfg_upper_a   = 36'd33562626000;
   logic [35:0] cfg_upper_b   = 36'd33562626000;
   logic [59:0] cfg_drive     = 60'd422336192005326000;
   logic [59:0] cfg_ready     = 60'd422315569453057500;
   logic [11:0] arm_width [6] = '{default: 12'd1500};
   logic [11:0] arm_sent  [6] = '{default: 12'd1501};

   rsp_payload_type expected_reports [$];

   joystick_servo_rate_integrator_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   // 12-bit field k of a packed bounds or preset word, field 0 in the lowest bits
   function automatic int packed_at(input logic [59:0] word, input int k);
      return int'(word[12*k +: 12]);
   endfunction

   function automatic int lower_bound(input int i);
      return (i < 3) ? packed_at(cfg_lower_a, i) : packed_at(cfg_lower_b, i - 3);
   endfunction

   function automatic int upper_bound(input int i);
      return (i < 3) ? packed_at(cfg_upper_a, i) : packed_at(cfg_upper_b, i - 3);
   endfunction

   // Inside the zone -> 0, beyond it -> pulled toward 0, exactly on the edge -> unchanged
   function automatic int past_dead_zone(input logic signed [15:0] v);
      int a;
      int dz;
      a  = v;
      dz = cfg_dead_zone;
      if (a < dz && a > -dz) return 0;
      if (a > dz)            return a - dz;
      if (a < -dz)           return a + dz;
      return a;
   endfunction

   // Pose load: servos 0..4 from the preset, claw to one of its bounds; becomes the sent set
   function automatic void take_pose(input logic [59:0] preset, input bit claw_open);
      for (int k = 0; k < 5; k++) arm_width[k] = preset[12*k +: 12];
      arm_width[SERVO_CLAW] = 12'(claw_open ? upper_bound(SERVO_CLAW)
                                            : lower_bound(SERVO_CLAW));
      arm_sent = arm_width;
   endfunction

   // Applies one request to the arm state and returns the result it must produce
   function automatic rsp_payload_type advance_arm(input req_payload_type item);
      int              x1, y1, x2, y2, lt, rt, s, lo, hi;
      int              joint_step [6];
      bit              show_sent;
      bit              changed;
      rsp_payload_type r;
      r         = '0;
      show_sent = 1'b0;
      changed   = 1'b0;
      case (item.command)
         CMD_JOYSTICK: begin
            x1 = past_dead_zone(item.stick1_x);
            y1 = past_dead_zone(item.stick1_y);
            x2 = past_dead_zone(item.stick2_x);
            y2 = past_dead_zone(item.stick2_y);
            lt = $signed(item.left_trigger);    // triggers skip the dead zone
            rt = $signed(item.right_trigger);
            joint_step[SERVO_BASE]     = (-x2) * ARM_RATE / ARM_SPAN;
            joint_step[SERVO_SHOULDER] = (-y2) * ARM_RATE / ARM_SPAN;
            joint_step[SERVO_ELBOW]    = y1 * ARM_RATE / ARM_SPAN;
            joint_step[SERVO_WRIST]    = (-(lt - rt)) * WRIST_RATE / ARM_SPAN;
            joint_step[SERVO_TURN]     = x1 * TURN_RATE / TURN_SPAN;
            joint_step[SERVO_CLAW]     = x1 * TURN_RATE / TURN_SPAN;
            // a step that would leave the servo's window is dropped
            for (int i = 0; i < 6; i++) begin
               s = int'(arm_width[i]) + joint_step[i];
               if (joint_step[i] != 0 && s <= upper_bound(i) && s >= lower_bound(i))
                  arm_width[i] = s[11:0];
            end
            for (int i = 0; i < 6; i++)
               if (arm_width[i] != arm_sent[i]) changed = 1'b1;
            if (changed) begin
               r.send   = 1'b1;
               arm_sent = arm_width;
            end
         end
         CMD_BUTTON: begin
            if (item.button_code == CLAW_TOGGLE_BUTTON) begin
               lo = lower_bound(SERVO_CLAW);
               hi = upper_bound(SERVO_CLAW);
               arm_width[SERVO_CLAW] = 12'((int'(arm_width[SERVO_CLAW]) == lo) ? hi : lo);
            end
         end
         CMD_RESET, CMD_STORAGE_READY, CMD_DRIVE_READY: begin
            take_pose(cfg_ready, 1'b0);
            r.send    = 1'b1;
            r.message = (item.command == CMD_RESET)         ? MSG_RESET :
                        (item.command == CMD_STORAGE_READY) ? MSG_STORAGE_READY :
                                                              MSG_DRIVE_READY;
         end
         CMD_READY_DRIVE: begin
            take_pose(cfg_drive, 1'b1);
            r.send    = 1'b1;
            r.message = MSG_READY_DRIVE;
         end
         CMD_RESEND: begin
            r.send    = 1'b1;
            show_sent = 1'b1;
         end
         default: ;
      endcase
      r.base_width       = show_sent ? arm_sent[SERVO_BASE]     : arm_width[SERVO_BASE];
      r.shoulder_width   = show_sent ? arm_sent[SERVO_SHOULDER] : arm_width[SERVO_SHOULDER];
      r.elbow_width      = show_sent ? arm_sent[SERVO_ELBOW]    : arm_width[SERVO_ELBOW];
      r.wrist_width      = show_sent ? arm_sent[SERVO_WRIST]    : arm_width[SERVO_WRIST];
      r.wrist_turn_width = show_sent ? arm_sent[SERVO_TURN]     : arm_width[SERVO_TURN];
      r.claw_width       = show_sent ? arm_sent[SERVO_CLAW]     : arm_width[SERVO_CLAW];
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic compare_field(input string name, input logic [11:0] want,
                                input logic [11:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   // Outputs are read at the edge, before any update scheduled for that edge
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $error("result transfer with no request outstanding");
            mismatch_count++;
         end else begin
            want = expected_reports.pop_front();
            results_checked++;
            if (rsp_payload.send === 1'b1) sends_seen++;
            compare_field("send",             want.send,             rsp_payload.send);
            compare_field("message",          want.message,          rsp_payload.message);
            compare_field("base_width",       want.base_width,       rsp_payload.base_width);
            compare_field("shoulder_width",   want.shoulder_width,   rsp_payload.shoulder_width);
            compare_field("elbow_width",      want.elbow_width,      rsp_payload.elbow_width);
            compare_field("wrist_width",      want.wrist_width,      rsp_payload.wrist_width);
            compare_field("wrist_turn_width", want.wrist_turn_width,
                          rsp_payload.wrist_turn_width);
            compare_field("claw_width",       want.claw_width,       rsp_payload.claw_width);
         end
      end
   end

   // Receiver back-pressure, redrawn every cycle
   always @(posedge clock)
      rsp_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run stopped: no completion within %0d cycles", CYCLE_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- driving

   // One request transfer; the expectation is queued as soon as the payload is committed
   task automatic push_request(input req_payload_type item);
      while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      expected_reports.push_back(advance_arm(item));
      requests_sent++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Stop sending and wait until every queued result has been checked, then some slack
   task automatic settle(input int extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_reports.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   // Register write, only with the block drained
   task automatic write_csr(input logic [2:0] idx, input logic [59:0] value);
      settle(4);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      csr_writes++;
      case (idx)
         CSR_DEAD_ZONE:      cfg_dead_zone = value[14:0];
         CSR_LOWER_BOUNDS_A: cfg_lower_a   = value[35:0];
         CSR_LOWER_BOUNDS_B: cfg_lower_b   = value[35:0];
         CSR_UPPER_BOUNDS_A: cfg_upper_a   = value[35:0];
         CSR_UPPER_BOUNDS_B: cfg_upper_b   = value[35:0];
         CSR_DRIVE_PRESET:   cfg_drive     = value;
         CSR_READY_PRESET:   cfg_ready     = value;
         default: ;
      endcase
   endtask

   // Register value in the low bits, random junk above the register's width
   function automatic logic [59:0] with_noise(input logic [59:0] v, input int bits);
      logic [59:0] keep;
      keep = (60'd1 << bits) - 60'd1;
      return (60'({$urandom, $urandom}) & ~keep) | (v & keep);
   endfunction

   function automatic req_payload_type joy(input int x1, y1, lt, x2, y2, rt);
      req_payload_type it;
      it.command       = CMD_JOYSTICK;
      it.stick1_x      = 16'(x1);
      it.stick1_y      = 16'(y1);
      it.left_trigger  = 16'(lt);
      it.stick2_x      = 16'(x2);
      it.stick2_y      = 16'(y2);
      it.right_trigger = 16'(rt);
      it.button_code   = 4'($urandom);
      return it;
   endfunction

   // Non-joystick command; stick fields carry junk that must be ignored
   function automatic req_payload_type cmd_item(input logic [2:0] cmd, input logic [3:0] btn);
      req_payload_type it;
      it             = joy($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      it.command     = cmd;
      it.button_code = btn;
      return it;
   endfunction

   function automatic logic [15:0] axis_value();
      int dz;
      int off;
      dz  = cfg_dead_zone;
      off = int'($urandom_range(4)) - 2;
      case ($urandom_range(9))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         3, 4:    return 16'(dz + off);        // around the dead-zone edge
         5, 6:    return 16'(-(dz + off));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] trigger_value();
      case ($urandom_range(5))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Mostly joystick traffic so widths walk into their bounds, with poses to recenter
   function automatic req_payload_type random_item();
      logic [127:0]    noise;
      req_payload_type it;
      int unsigned     pick;
      noise = {$urandom, $urandom, $urandom, $urandom};
      it    = noise[$bits(req_payload_type)-1:0];
      pick  = $urandom_range(99);
      if (pick < 62) begin
         it.command       = CMD_JOYSTICK;
         it.stick1_x      = axis_value();
         it.stick1_y      = axis_value();
         it.stick2_x      = axis_value();
         it.stick2_y      = axis_value();
         it.left_trigger  = trigger_value();
         it.right_trigger = trigger_value();
      end else if (pick < 72) begin
         it.command = CMD_BUTTON;
         if ($urandom_range(1)) it.button_code = CLAW_TOGGLE_BUTTON;
      end else if (pick < 84) begin
         it.command = 3'($urandom_range(CMD_RESET, CMD_DRIVE_READY));
      end else if (pick < 94) begin
         it.command = CMD_RESEND;
      end else begin
         it.command = 3'($urandom_range(7));    // any code, the undecoded one included
      end
      return it;
   endfunction

   // Narrow windows around random centers; now and then a servo gets crossed bounds
   task automatic load_random_setup();
      logic [59:0] lo_a, lo_b, hi_a, hi_b, drv, rdy, dz;
      int          k, mid, lo, hi;
      lo_a = '0; lo_b = '0; hi_a = '0; hi_b = '0; drv = '0; rdy = '0;
      for (k = 0; k < 6; k++) begin
         mid = 1100 + $urandom_range(800);
         lo  = mid - int'($urandom_range(120));
         hi  = mid + int'($urandom_range(120));
         if ($urandom_range(7) == 0) {lo, hi} = {hi, lo};
         if (k < 3) begin
            lo_a[12*k +: 12] = 12'(lo);
            hi_a[12*k +: 12] = 12'(hi);
         end else begin
            lo_b[12*(k-3) +: 12] = 12'(lo);
            hi_b[12*(k-3) +: 12] = 12'(hi);
         end
         if (k < 5) begin
            drv[12*k +: 12] = 12'(mid + int'($urandom_range(60)) - 30);
            rdy[12*k +: 12] = 12'(mid + int'($urandom_range(60)) - 30);
         end
      end
      case ($urandom_range(3))
         0:       dz = 60'd0;
         1:       dz = 60'($urandom_range(1, 300));
         2:       dz = 60'($urandom_range(2000, 9000));
         default: dz = 60'($urandom_range(32767));
      endcase
      write_csr(CSR_DEAD_ZONE,      with_noise(dz, 15));
      write_csr(CSR_LOWER_BOUNDS_A, with_noise(lo_a, 36));
      write_csr(CSR_LOWER_BOUNDS_B, with_noise(lo_b, 36));
      write_csr(CSR_UPPER_BOUNDS_A, with_noise(hi_a, 36));
      write_csr(CSR_UPPER_BOUNDS_B, with_noise(hi_b, 36));
      write_csr(CSR_DRIVE_PRESET,   drv);
      write_csr(CSR_READY_PRESET,   rdy);
   endtask

   // ---------------------------------------------------------------- tests

   // Power-up state: resend shows the 1501 set, ignored commands change nothing,
   // the first idle joystick sends because 1500 differs from 1501, the second does not
   task automatic test_power_up_state();
      push_request(cmd_item(CMD_RESEND, 4'd0));
      push_request(cmd_item(CMD_UNUSED, CLAW_TOGGLE_BUTTON));
      push_request(cmd_item(CMD_BUTTON, 4'd0));
      push_request(cmd_item(CMD_BUTTON, 4'd15));
      push_request(joy(0, 0, 0, 0, 0, 0));
      push_request(joy(0, 0, 0, 0, 0, 0));
   endtask

   // Default dead zone of 5000: just inside, exactly on, just past, full scale; then poses
   task automatic test_stick_edges();
      push_request(joy(4999, -4999, 0, 4999, -4999, 0));
      push_request(joy(5000, 5000, 0, -5000, -5000, 0));
      push_request(joy(-5000, -5000, 0, 5000, 5000, 0));
      push_request(joy(5001, -5001, 0, 5001, -5001, 0));
      push_request(joy(32767, 32767, -32768, 32767, 32767, 32767));
      push_request(joy(-32768, -32768, 32767, -32768, -32768, -32768));
      push_request(joy(0, 0, 32767, 0, 0, 32767));
      // claw toggle: off its lower bound -> lower, then lower -> upper
      push_request(cmd_item(CMD_BUTTON, CLAW_TOGGLE_BUTTON));
      push_request(cmd_item(CMD_BUTTON, CLAW_TOGGLE_BUTTON));
      push_request(cmd_item(CMD_BUTTON, 4'd2));
      push_request(cmd_item(CMD_RESET, 4'd0));
      push_request(cmd_item(CMD_STORAGE_READY, 4'd0));
      push_request(cmd_item(CMD_READY_DRIVE, 4'd0));
      push_request(cmd_item(CMD_DRIVE_READY, 4'd0));
      push_request(joy(32767, 0, 0, 0, 0, 0));
      push_request(cmd_item(CMD_RESEND, 4'd0));
   endtask

   task automatic test_register_extremes();
      // no dead zone: the smallest deflections already count
      write_csr(CSR_DEAD_ZONE, with_noise(60'd0, 15));
      push_request(joy(1, -1, 0, -1, 1, 0));
      push_request(joy(-32768, 32767, 32767, 32767, -32768, -32768));
      // widest dead zone: only codes on or past its edge (+-32767, -32768) get through
      write_csr(CSR_DEAD_ZONE, with_noise(60'h7fff, 15));
      push_request(joy(32767, -32767, 0, 32767, -32767, 0));
      push_request(joy(-32768, 32766, 0, -32768, 32766, 0));
      // full-range windows, poses on the rails: steps past 0 or 4095 are dropped
      write_csr(CSR_DEAD_ZONE,      with_noise(60'd0, 15));
      write_csr(CSR_LOWER_BOUNDS_A, with_noise(60'd0, 36));
      write_csr(CSR_LOWER_BOUNDS_B, with_noise(60'd0, 36));
      write_csr(CSR_UPPER_BOUNDS_A, with_noise('1, 36));
      write_csr(CSR_UPPER_BOUNDS_B, with_noise('1, 36));
      write_csr(CSR_DRIVE_PRESET,   '1);
      write_csr(CSR_READY_PRESET,   60'd0);
      push_request(cmd_item(CMD_READY_DRIVE, 4'd0));
      push_request(joy(32767, 32767, -32768, -32768, -32768, 32767));
      push_request(joy(-32768, -32768, 32767, 32767, 32767, -32768));
      push_request(cmd_item(CMD_DRIVE_READY, 4'd0));
      push_request(joy(-32768, -32768, 32767, 32767, 32767, -32768));
      push_request(cmd_item(CMD_BUTTON, CLAW_TOGGLE_BUTTON));
      push_request(cmd_item(CMD_RESEND, 4'd0));
      // crossed bounds: no step fits, the claw still toggles
      write_csr(CSR_LOWER_BOUNDS_A, with_noise('1, 36));
      write_csr(CSR_LOWER_BOUNDS_B, with_noise('1, 36));
      write_csr(CSR_UPPER_BOUNDS_A, with_noise(60'd0, 36));
      write_csr(CSR_UPPER_BOUNDS_B, with_noise(60'd0, 36));
      push_request(joy(32767, 32767, -32768, -32768, -32768, 32767));
      push_request(joy(-32768, -32768, 32767, 32767, 32767, -32768));
      push_request(cmd_item(CMD_BUTTON, CLAW_TOGGLE_BUTTON));
      push_request(cmd_item(CMD_BUTTON, CLAW_TOGGLE_BUTTON));
      push_request(cmd_item(CMD_STORAGE_READY, 4'd0));
      // write past the register file: no register may change
      write_csr(CSR_UNUSED_INDEX, with_noise(60'd0, 0));
      push_request(cmd_item(CMD_RESET, 4'd0));
      push_request(cmd_item(CMD_READY_DRIVE, 4'd0));
   endtask

   // Random traffic under one idle/stall mix, with a full drain every 40 requests
   task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
      int n;
      load_random_setup();
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
      for (n = 0; n < count; n++) begin
         if (n % 40 == 39) settle(0);
         push_request(random_item());
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_power_up_state();
      test_stick_edges();
      test_register_extremes();
      test_random_traffic(103, 0, 0);
      test_random_traffic(103, 82, 0);
      test_random_traffic(103, 0, 82);
      test_random_traffic(103, 35, 35);

      settle(10);
      $display("covered %0d requests (%0d sent a message) and %0d register writes, four mixes",
               requests_sent, sends_seen, csr_writes);
      $display("%0d results compared, %0d mismatches", results_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
